>>> hdl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// types, codes and constants shared by the socks5 reply parser
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    localparam logic [7:0] SOCKS_VER     = 8'h05;
    localparam logic [7:0] AUTH_VER      = 8'h01;
    localparam logic [7:0] AUTH_STATUS_OK = 8'h00;
    localparam logic [7:0] REPLY_OK      = 8'h00;
    localparam logic [7:0] METH_NO_AUTH  = 8'h00;
    localparam logic [7:0] METH_USERPASS = 8'h02;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_IPV6     = 8'h04;

    localparam int HDR_BYTES      = 4;
    localparam int PORT_BYTES     = 2;
    localparam int METHOD_MIN_LEN = 2;
    localparam int AUTH_LEN       = 2;
    localparam int REPLY_MIN_LEN  = 4;
    localparam int DOMAIN_MIN_LEN = 5;
    localparam int LEN_IPV4       = HDR_BYTES + 4 + PORT_BYTES;
    localparam int LEN_IPV6       = HDR_BYTES + 16 + PORT_BYTES;
    localparam int DOMAIN_OVHD    = HDR_BYTES + 1 + PORT_BYTES;
    localparam int POS_ATYP       = 3;
    localparam int POS_ADDR       = 4;
    localparam int POS_DOMAIN     = 5;
    localparam int POS_IPV4_END   = LEN_IPV4 - PORT_BYTES - 1;
    localparam int POS_IPV6_END   = LEN_IPV6 - PORT_BYTES - 1;

    typedef enum logic [1:0] {
        PH_METHOD  = 2'd0,
        PH_AUTH    = 2'd1,
        PH_REQUEST = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ERR_OK          = 4'd0,
        ERR_METHOD_HDR  = 4'd1,
        ERR_METHOD_BAD  = 4'd2,
        ERR_AUTH_LEN    = 4'd3,
        ERR_AUTH_VER    = 4'd4,
        ERR_AUTH_REJ    = 4'd5,
        ERR_REPLY_SHORT = 4'd6,
        ERR_REPLY_VER   = 4'd7,
        ERR_REPLY_FAIL  = 4'd8,
        ERR_ATYP        = 4'd9,
        ERR_ADDR_LEN    = 4'd10
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        addr_valid;
        logic [7:0]  addr_byte;
        logic        frame_done;
        logic        accepted;
        t_err        error_code;
        t_phase      phase_now;
        logic [7:0]  chosen_method;
        logic [7:0]  address_type;
        logic [15:0] bound_port;
    } t_out_item;

endpackage

>>> hdl/srp_ifs.sv
// ----------------------------------------------------------------------------
// srp_ifs
// valid/ready channels carrying reply bytes in and parse results out
// ----------------------------------------------------------------------------
interface srp_in_if;
    import srp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srp_out_if;
    import srp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/srp_core.sv
// ----------------------------------------------------------------------------
// srp_core
// parser state and single-pass judgement of one reply byte
// ----------------------------------------------------------------------------
module srp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  srp_pkg::t_in_item  i_item,
    output srp_pkg::t_out_item o_result
);
    import srp_pkg::*;

    t_phase           r_phase,         n_phase;
    logic [CNT_W-1:0] r_byte_count,    n_byte_count;
    logic [7:0]       r_hdr [HDR_BYTES];
    logic [7:0]       n_hdr [HDR_BYTES];
    logic [7:0]       r_domain_length, n_domain_length;
    logic [15:0]      r_port_shift,    n_port_shift;
    logic [7:0]       r_method_seen,   n_method_seen;

    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] dom_end;
    logic [CNT_W-1:0] dom_len_total;
    logic [7:0]       b;
    logic             in_span;
    t_err             err;

    always_comb begin
        b       = i_item.data_byte;
        pos     = r_byte_count;
        len     = (pos < CNT_MAX) ? pos + 1'b1 : CNT_MAX;

        for (int i = 0; i < HDR_BYTES; i++) begin
            n_hdr[i] = (pos == CNT_W'(i)) ? b : r_hdr[i];
        end
        n_domain_length = (pos == CNT_W'(POS_ADDR)) ? b : r_domain_length;
        n_port_shift    = {r_port_shift[7:0], b};
        n_method_seen   = r_method_seen;
        n_phase         = r_phase;
        n_byte_count    = len;

        dom_end       = CNT_W'(POS_ADDR) + CNT_W'(n_domain_length);
        dom_len_total = CNT_W'(DOMAIN_OVHD) + CNT_W'(n_domain_length);

        o_result = '0;

        // address streaming
        if (r_phase == PH_REQUEST) begin
            if (pos >= CNT_W'(POS_ATYP)) begin
                o_result.address_type = n_hdr[3];
            end
            in_span = 1'b0;
            case (n_hdr[3])
                ATYP_IPV4:   in_span = pos <= CNT_W'(POS_IPV4_END);
                ATYP_IPV6:   in_span = pos <= CNT_W'(POS_IPV6_END);
                ATYP_DOMAIN: in_span = (pos >= CNT_W'(POS_DOMAIN)) && (pos <= dom_end);
                default:     in_span = 1'b0;
            endcase
            if (pos >= CNT_W'(POS_ADDR) && n_hdr[0] == SOCKS_VER && n_hdr[1] == REPLY_OK
                && in_span) begin
                o_result.addr_valid = 1'b1;
                o_result.addr_byte  = b;
            end
        end else begin
            in_span = 1'b0;
        end

        // verdict on the last byte
        err = ERR_OK;
        if (i_item.last_byte) begin
            case (r_phase)
                PH_METHOD: begin
                    if (len < CNT_W'(METHOD_MIN_LEN) || n_hdr[0] != SOCKS_VER) begin
                        err = ERR_METHOD_HDR;
                    end else begin
                        n_method_seen = n_hdr[1];
                        if (n_hdr[1] == METH_NO_AUTH) begin
                            n_phase = PH_REQUEST;
                        end else if (n_hdr[1] == METH_USERPASS) begin
                            n_phase = PH_AUTH;
                        end else begin
                            err = ERR_METHOD_BAD;
                        end
                    end
                end
                PH_REQUEST: begin
                    if (len < CNT_W'(REPLY_MIN_LEN)) begin
                        err = ERR_REPLY_SHORT;
                    end else if (n_hdr[0] != SOCKS_VER) begin
                        err = ERR_REPLY_VER;
                    end else if (n_hdr[1] != REPLY_OK) begin
                        err = ERR_REPLY_FAIL;
                    end else begin
                        case (n_hdr[3])
                            ATYP_IPV4: begin
                                if (len != CNT_W'(LEN_IPV4)) err = ERR_ADDR_LEN;
                            end
                            ATYP_IPV6: begin
                                if (len != CNT_W'(LEN_IPV6)) err = ERR_ADDR_LEN;
                            end
                            ATYP_DOMAIN: begin
                                if (len < CNT_W'(DOMAIN_MIN_LEN) || len != dom_len_total) begin
                                    err = ERR_ADDR_LEN;
                                end
                            end
                            default: err = ERR_ATYP;
                        endcase
                        if (err == ERR_OK) begin
                            n_phase             = PH_DONE;
                            o_result.bound_port = n_port_shift;
                        end
                    end
                end
                default: begin
                    if (len != CNT_W'(AUTH_LEN)) begin
                        err = ERR_AUTH_LEN;
                    end else if (n_hdr[0] != AUTH_VER) begin
                        err = ERR_AUTH_VER;
                    end else if (n_hdr[1] != AUTH_STATUS_OK) begin
                        err = ERR_AUTH_REJ;
                    end else begin
                        n_phase = PH_REQUEST;
                    end
                end
            endcase
            n_byte_count = '0;
            n_port_shift = '0;
        end

        o_result.frame_done    = i_item.last_byte;
        o_result.accepted      = i_item.last_byte && (err == ERR_OK);
        o_result.error_code    = err;
        o_result.phase_now     = n_phase;
        o_result.chosen_method = n_method_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_METHOD;
            r_byte_count    <= '0;
            r_domain_length <= '0;
            r_port_shift    <= '0;
            r_method_seen   <= '0;
            for (int i = 0; i < HDR_BYTES; i++) begin
                r_hdr[i] <= '0;
            end
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_byte_count    <= n_byte_count;
            r_domain_length <= n_domain_length;
            r_port_shift    <= n_port_shift;
            r_method_seen   <= n_method_seen;
            for (int i = 0; i < HDR_BYTES; i++) begin
                r_hdr[i] <= n_hdr[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_byte_count == '0)
        else $error("byte count not cleared after last byte");

    a_count_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.last_byte && r_byte_count < CNT_MAX
        |=> r_byte_count == $past(r_byte_count) + 1'b1)
        else $error("byte count did not advance");

    a_port_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_port_shift == '0)
        else $error("port shift not cleared after last byte");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_method_seen))
        else $error("parser state moved without an item");
`endif

endmodule

>>> hdl/socks5_reply_parser.sv
// ----------------------------------------------------------------------------
// socks5_reply_parser
// client-side socks5 server reply parser, one byte per item
// ----------------------------------------------------------------------------
// a result is offered from the result register once its byte has left the input
// register, and is held back while an older result still waits
// throughput: one byte per cycle, sustained while the result side takes items
// the input register feeds the judgement logic, the result register holds
// its output, so a new byte is taken into an empty input register while a result still waits
// reset: synchronous active-low, returns to method phase with all counts clear
// ----------------------------------------------------------------------------
module socks5_reply_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srp_in_if.sink           i_in,
    srp_out_if.source        o_out
);
    import srp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_adv;
    t_out_item w_result;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    srp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
        if (w_adv) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("pending item dropped from input register");

    a_port_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.accepted |-> r_out_item.bound_port == '0)
        else $error("port given on a rejected message");

    a_addr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.addr_valid
        |-> r_out_item.phase_now == PH_REQUEST
            || (r_out_item.accepted && r_out_item.phase_now == PH_DONE))
        else $error("address byte outside request phase");
`endif

endmodule

>>> tb/socks5_reply_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// socks5_reply_parser_tb
// self-checking bench for the socks5 reply parser: a scripted pass through
// method selection, authentication and request replies, then random request and auth replies,
// each result checked field by field against a behavioural parser model
// ----------------------------------------------------------------------------
module socks5_reply_parser_tb;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 480;
    localparam int LONG_AFTER   = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 150;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        t_phase          ph;
        logic [15:0]     count;
        logic [3:0][7:0] hdr;
        logic [7:0]      dom_len;
        logic [15:0]     port_sh;
        logic [7:0]      meth;
    } t_parser_state;

    logic i_clk;
    logic i_rst_n;

    srp_in_if  in_ch ();
    srp_out_if out_ch ();

    socks5_reply_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_in_item      reply_bytes_q[$];
    t_out_item     expected_results[$];
    t_parser_state plan_state;
    t_parser_state model_state;
    t_out_item     predicted;
    t_out_item     want;

    int n_planned;
    int n_accepted;
    int n_fail;
    int cycle_cnt;
    int gap_left;
    int burst_left;
    int stall_mode;
    int stall_left;
    logic hold_off;
    logic take;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_out_item parse_reply_byte(inout t_parser_state st,
                                                    input t_in_item it);
        t_out_item   r;
        int unsigned pos;
        int unsigned len;
        t_phase      start_ph;
        t_err        err;
        logic        in_span;
        r        = '0;
        pos      = st.count;
        len      = (pos < MAX_FRAME_BYTES) ? pos + 1 : MAX_FRAME_BYTES;
        start_ph = st.ph;
        err      = ERR_OK;
        in_span  = 1'b0;
        if (pos < HDR_BYTES) begin
            st.hdr[pos] = it.data_byte;
        end
        if (pos == POS_ADDR) begin
            st.dom_len = it.data_byte;
        end
        st.port_sh = {st.port_sh[7:0], it.data_byte};

        if (start_ph == PH_REQUEST) begin
            if (pos >= POS_ATYP) begin
                r.address_type = st.hdr[POS_ATYP];
            end
            if (pos >= POS_ADDR && st.hdr[0] == SOCKS_VER && st.hdr[1] == REPLY_OK) begin
                case (st.hdr[POS_ATYP])
                    ATYP_IPV4:   in_span = (pos <= POS_IPV4_END);
                    ATYP_IPV6:   in_span = (pos <= POS_IPV6_END);
                    ATYP_DOMAIN: in_span = (pos >= POS_DOMAIN) && (pos <= POS_ADDR + st.dom_len);
                    default:     in_span = 1'b0;
                endcase
                if (in_span) begin
                    r.addr_valid = 1'b1;
                    r.addr_byte  = it.data_byte;
                end
            end
        end

        if (it.last_byte) begin
            case (start_ph)
                PH_METHOD: begin
                    if (len < METHOD_MIN_LEN || st.hdr[0] != SOCKS_VER) begin
                        err = ERR_METHOD_HDR;
                    end else begin
                        st.meth = st.hdr[1];
                        if (st.meth == METH_NO_AUTH) begin
                            st.ph = PH_REQUEST;
                        end else if (st.meth == METH_USERPASS) begin
                            st.ph = PH_AUTH;
                        end else begin
                            err = ERR_METHOD_BAD;
                        end
                    end
                end
                PH_REQUEST: begin
                    if (len < REPLY_MIN_LEN) begin
                        err = ERR_REPLY_SHORT;
                    end else if (st.hdr[0] != SOCKS_VER) begin
                        err = ERR_REPLY_VER;
                    end else if (st.hdr[1] != REPLY_OK) begin
                        err = ERR_REPLY_FAIL;
                    end else begin
                        case (st.hdr[POS_ATYP])
                            ATYP_IPV4: begin
                                if (len != LEN_IPV4) err = ERR_ADDR_LEN;
                            end
                            ATYP_IPV6: begin
                                if (len != LEN_IPV6) err = ERR_ADDR_LEN;
                            end
                            ATYP_DOMAIN: begin
                                if (len < DOMAIN_MIN_LEN || len != DOMAIN_OVHD + st.dom_len)
                                    err = ERR_ADDR_LEN;
                            end
                            default: err = ERR_ATYP;
                        endcase
                        if (err == ERR_OK) begin
                            st.ph        = PH_DONE;
                            r.bound_port = st.port_sh;
                        end
                    end
                end
                default: begin
                    // auth rule, also for traffic once the request is done
                    if (len != AUTH_LEN) begin
                        err = ERR_AUTH_LEN;
                    end else if (st.hdr[0] != AUTH_VER) begin
                        err = ERR_AUTH_VER;
                    end else if (st.hdr[1] != AUTH_STATUS_OK) begin
                        err = ERR_AUTH_REJ;
                    end else begin
                        st.ph = PH_REQUEST;
                    end
                end
            endcase
            r.accepted = (err == ERR_OK);
            st.count   = '0;
            st.port_sh = '0;
        end else begin
            st.count = 16'(len);
        end
        r.frame_done    = it.last_byte;
        r.error_code    = err;
        r.phase_now     = st.ph;
        r.chosen_method = st.meth;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    function automatic t_byte_q make_request(input logic [7:0] ver, input logic [7:0] rep,
                                             input logic [7:0] atyp, input int addr_len);
        t_byte_q m;
        m = {};
        m.push_back(ver);
        m.push_back(rep);
        m.push_back(8'($urandom));
        m.push_back(atyp);
        if (atyp == ATYP_DOMAIN) begin
            m.push_back(8'(addr_len));
        end
        repeat (addr_len) m.push_back(8'($urandom));
        repeat (PORT_BYTES) m.push_back(8'($urandom));
        return m;
    endfunction

    function automatic t_byte_q make_good_request();
        int sel;
        int dl;
        sel = $urandom_range(0, 2);
        dl  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
        if (sel == 0) begin
            return make_request(SOCKS_VER, REPLY_OK, ATYP_IPV4, 4);
        end else if (sel == 1) begin
            return make_request(SOCKS_VER, REPLY_OK, ATYP_IPV6, 16);
        end
        return make_request(SOCKS_VER, REPLY_OK, ATYP_DOMAIN, dl);
    endfunction

    task automatic queue_message(input t_byte_q msg);
        t_in_item  it;
        t_out_item ignored;
        foreach (msg[i]) begin
            it.data_byte = msg[i];
            it.last_byte = (i == msg.size() - 1);
            ignored      = parse_reply_byte(plan_state, it);
            reply_bytes_q.push_back(it);
            n_planned++;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predicted = parse_reply_byte(model_state, in_ch.data);
                expected_results.push_back(predicted);
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0 || reply_bytes_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= reply_bytes_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: checks each result and stalls on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no byte waiting for one");
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("addr_valid", 16'(want.addr_valid), 16'(out_ch.data.addr_valid));
                    check_field("addr_byte", 16'(want.addr_byte), 16'(out_ch.data.addr_byte));
                    check_field("frame_done", 16'(want.frame_done), 16'(out_ch.data.frame_done));
                    check_field("accepted", 16'(want.accepted), 16'(out_ch.data.accepted));
                    check_field("error_code", 16'(want.error_code), 16'(out_ch.data.error_code));
                    check_field("phase_now", 16'(want.phase_now), 16'(out_ch.data.phase_now));
                    check_field("chosen_method", 16'(want.chosen_method),
                                16'(out_ch.data.chosen_method));
                    check_field("address_type", 16'(want.address_type),
                                16'(out_ch.data.address_type));
                    check_field("bound_port", want.bound_port, out_ch.data.bound_port);
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 120);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       take = 1'b1;
                1:       take = 1'($urandom_range(0, 1));
                default: take = (cycle_cnt % 5) >= 2;
            endcase
            out_ch.ready <= take && !hold_off;
        end
    end

    // long receiver hold-off so the parser fills and pushes back
    initial begin
        while (n_accepted < HOLD_AFTER) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_byte_q msg;
        int      kind;
        int      directed_n;
        logic    long_sent;
        logic [7:0] v;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        hold_off     = 1'b0;
        plan_state   = '0;
        model_state  = '0;
        n_planned    = 0;
        n_accepted   = 0;
        n_fail       = 0;
        cycle_cnt    = 0;
        gap_left     = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_left   = 0;
        long_sent    = 1'b0;

        // method selection: short, bad version, unknown method, then user/pass
        queue_message({SOCKS_VER});
        queue_message({8'h04, METH_NO_AUTH});
        queue_message({SOCKS_VER, 8'h07});
        queue_message({SOCKS_VER, METH_USERPASS, 8'hff});
        // auth: wrong length, bad version, rejected, then ok
        queue_message({AUTH_VER, AUTH_STATUS_OK, 8'h00});
        queue_message({8'h02, AUTH_STATUS_OK});
        queue_message({AUTH_VER, 8'hff});
        queue_message({AUTH_VER, AUTH_STATUS_OK});
        // domain reply with no length byte, then an empty domain
        queue_message({SOCKS_VER, REPLY_OK, 8'h00, ATYP_DOMAIN});
        queue_message({SOCKS_VER, REPLY_OK, 8'hff, ATYP_DOMAIN, 8'h00, 8'hff, 8'hff});
        // auth traffic after the request goes back to request phase
        queue_message({AUTH_VER, AUTH_STATUS_OK});
        directed_n = n_planned;

        while (n_planned < directed_n + RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (!long_sent && n_planned > directed_n + LONG_AFTER) begin
                // widest domain, then run on past the byte counter limit
                msg = make_request(SOCKS_VER, REPLY_OK, ATYP_DOMAIN, 255);
                while (msg.size() <= MAX_FRAME_BYTES + $urandom_range(0, 16))
                    msg.push_back(8'($urandom));
                long_sent = 1'b1;
            end else if (plan_state.ph == PH_DONE && kind < 80) begin
                if (kind < 60) begin
                    msg = {AUTH_VER, AUTH_STATUS_OK};
                end else if (kind < 65) begin
                    msg = {AUTH_VER};
                end else if (kind < 70) begin
                    msg = {AUTH_VER, AUTH_STATUS_OK, 8'($urandom)};
                end else begin
                    msg = {8'($urandom), 8'($urandom)};
                end
            end else if (kind < 55) begin
                msg = make_good_request();
            end else if (kind < 65) begin
                msg = make_good_request();
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        if (msg.size() > 1) msg.pop_back();
                    end
                end
            end else if (kind < 72) begin
                msg = make_good_request();
                do v = 8'($urandom); while (v == SOCKS_VER);
                msg[0] = v;
            end else if (kind < 79) begin
                msg = make_good_request();
                msg[1] = 8'($urandom_range(1, 255));
            end else if (kind < 86) begin
                do v = 8'($urandom); while (v == ATYP_IPV4 || v == ATYP_DOMAIN || v == ATYP_IPV6);
                msg = make_request(SOCKS_VER, REPLY_OK, v, $urandom_range(0, 20));
            end else if (kind < 92) begin
                msg = {};
                repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
            end else if (kind < 96) begin
                msg = {AUTH_VER, AUTH_STATUS_OK};
            end else begin
                msg = {};
                repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
            end
            queue_message(msg);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_planned || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
